// ===== design/scsm_pkg.sv =====
// Shared constants, register map and helper functions of the stacked circle slice merger.
package scsm_pkg;

	localparam int MAX_SLICES_DEF = 64;

	localparam int XY_W   = 16;
	localparam int RAD_W  = 12;
	localparam int Z_W    = 16;
	localparam int THK_W  = 10;
	localparam int TOL_W  = 12;
	localparam int MINS_W = 7;
	localparam int HGT_W  = 16;
	localparam int CNT_W  = 7;
	localparam int PCT_W  = 7;
	localparam int ID_W   = 16;

	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 128;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	localparam logic [2:0] REG_THICKNESS  = 3'd0;
	localparam logic [2:0] REG_CENTER_TOL = 3'd1;
	localparam logic [2:0] REG_RADIUS_TOL = 3'd2;
	localparam logic [2:0] REG_MIN_SLICES = 3'd3;
	localparam logic [2:0] REG_MIN_HEIGHT = 3'd4;

	localparam logic [THK_W-1:0]  THICKNESS_RST  = 10'd50;
	localparam logic [TOL_W-1:0]  CENTER_TOL_RST = 12'd50;
	localparam logic [TOL_W-1:0]  RADIUS_TOL_RST = 12'd30;
	localparam logic [MINS_W-1:0] MIN_SLICES_RST = 7'd3;
	localparam logic [HGT_W-1:0]  MIN_HEIGHT_RST = 16'd300;

	// Height of a span, clamped at zero when the top lies below the bottom.
	function automatic logic [HGT_W-1:0] span_height(input logic signed [Z_W-1:0] bot,
			input logic signed [Z_W-1:0] top);
		logic signed [Z_W:0] d;
		d = {top[Z_W-1], top} - {bot[Z_W-1], bot};
		return d[Z_W] ? '0 : d[Z_W-1:0];
	endfunction

	// Saturates an 18-bit sum to the signed 16-bit range.
	function automatic logic signed [Z_W-1:0] sat_z(input logic signed [Z_W+1:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[Z_W-1:0];
		end
	endfunction

endpackage

// ===== design/stacked_circle_slice_merger.sv =====
// Top level of the stacked circle slice merger: sequencer, shared divider and multiplier.
//
// Slices enter bottom to top on the s_ channel, one word per slice, and merged
// groups leave on the m_ channel as soon as they close. A slice may cause zero,
// one or two group words; m_tlast marks the last word caused by a slice.
// The block takes one slice at a time and drops s_tready until it is done.
// A slice that opens a group or is a failed fit runs no division unless the
// group it closes has merged slices since the last division.
// A slice tested against an open group whose means are stale first runs one
// restoring divider three times (x, y, radius) over SW = 16 + log2(MAX_SLICES)
// quotient bits, followed by the squaring steps S_SQX, S_SQY and S_SQC on
// the shared multiplier and the compare step S_CMP. Closing a group that
// has merged slices since the last division adds another divider pass
// before its word. In the worst case a slice therefore runs the divider pass
// twice, plus any time spent waiting on a stalled receiver.
// The output register holds one word; a stalled receiver only stops the block
// when a second word is ready, and the input side waits meanwhile.
// Reset closes any open group, loads the register defaults and clears the
// detection identifier, which otherwise runs on and wraps across frames.
// The user must write registers over the APB port only while idle; the block does not enforce it.
module stacked_circle_slice_merger #(
	parameter int MAX_SLICES = scsm_pkg::MAX_SLICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// fit_center_x, fit_center_y, fit_radius, slice_center_z, zero fill
	input  logic [scsm_pkg::S_DATA_W-1:0] s_tdata,
	// fit_ok
	input  logic                          s_tuser,
	// frame_end
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// mean_center_x, mean_center_y, mean_radius, base_z, top_z, group_height,
	// slice_count, confidence_pct, detection_id, zero fill
	output logic [scsm_pkg::M_DATA_W-1:0] m_tdata,
	// last_result
	output logic                          m_tlast,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scsm_pkg::APB_AW-1:0]   paddr,
	input  logic [scsm_pkg::APB_DW-1:0]   pwdata,
	output logic [scsm_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import scsm_pkg::*;

	localparam int CW = $clog2(MAX_SLICES + 1);
	localparam int SW = XY_W + $clog2(MAX_SLICES);
	localparam int RW = RAD_W + $clog2(MAX_SLICES);
	localparam int BW = $clog2(SW);
	localparam int QW = (CW > MINS_W) ? CW : MINS_W;
	localparam int PW = 2 * (XY_W + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECIDE = 4'd1;
	localparam logic [3:0] S_START  = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_SQX    = 4'd4;
	localparam logic [3:0] S_SQY    = 4'd5;
	localparam logic [3:0] S_SQC    = 4'd6;
	localparam logic [3:0] S_CMP    = 4'd7;
	localparam logic [3:0] S_CLOSE  = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;
	localparam logic [3:0] S_FEND   = 4'd10;

	localparam logic [1:0] AFT_FEND  = 2'd0;
	localparam logic [1:0] AFT_START = 2'd1;
	localparam logic [1:0] AFT_DONE  = 2'd2;

	localparam logic [1:0] DSEL_X = 2'd0;
	localparam logic [1:0] DSEL_Y = 2'd1;
	localparam logic [1:0] DSEL_R = 2'd2;

	localparam logic DRET_CMP  = 1'b0;
	localparam logic DRET_EMIT = 1'b1;

	logic [THK_W-1:0]  thick_q;
	logic [TOL_W-1:0]  ctol_q;
	logic [TOL_W-1:0]  rtol_q;
	logic [MINS_W-1:0] mins_q;
	logic [HGT_W-1:0]  minh_q;

	logic [3:0] state_q;
	logic [1:0] after_q;
	logic       dret_q;

	logic signed [XY_W-1:0] in_cx_q, in_cy_q;
	logic [RAD_W-1:0]       in_r_q;
	logic                   in_ok_q, in_fend_q;
	logic signed [Z_W-1:0]  in_z_q;

	logic                   grp_open_q;
	logic signed [SW-1:0]   sum_x_q, sum_y_q;
	logic [RW-1:0]          sum_r_q;
	logic signed [Z_W-1:0]  grp_bot_q, grp_top_q;
	logic [CW-1:0]          cnt_q;
	logic [ID_W-1:0]        next_id_q;

	logic                   means_vld_q;
	logic signed [XY_W-1:0] mean_x_q, mean_y_q;
	logic [RAD_W-1:0]       mean_r_q;

	logic [1:0]    div_sel_q;
	logic          div_ld_q;
	logic          div_neg_q;
	logic [BW-1:0] div_bit_q;
	logic [SW-1:0] div_quo_q;
	logic [CW-1:0] div_rem_q;

	logic signed [PW-1:0] prod_q;
	logic [PW:0]          acc_q;

	logic                  m_tvalid_q, m_tlast_q;
	logic [M_DATA_W-1:0]   m_tdata_q;

	logic signed [Z_W-1:0] new_bot, new_top;
	logic [THK_W-2:0]      half;
	logic signed [XY_W:0]  dx, dy, mul_op;
	logic signed [RAD_W:0] dr;
	logic [RAD_W:0]        dr_abs;
	logic [SW-1:0]         dvd, dvd_mag, quo_next, quo_res;
	logic                  dvd_neg;
	logic [CW:0]           shifted, trial;
	logic                  div_ge;
	logic [CW-1:0]         rem_next;
	logic [QW-1:0]         cnt_w;
	logic [HGT_W-1:0]      grp_h;
	logic                  grp_qual, new_qual, out_free, apb_wr;
	logic [CNT_W-1:0]      cnt_out;
	logic [PCT_W-1:0]      pct_out;
	logic [3:0]            after_state;

	assign half    = thick_q[THK_W-1:1];
	assign new_bot = sat_z({{2{in_z_q[Z_W-1]}}, in_z_q} - {{(Z_W+2-(THK_W-1)){1'b0}}, half});
	assign new_top = sat_z({{2{in_z_q[Z_W-1]}}, in_z_q} + {{(Z_W+2-(THK_W-1)){1'b0}}, half});

	assign dx     = {in_cx_q[XY_W-1], in_cx_q} - {mean_x_q[XY_W-1], mean_x_q};
	assign dy     = {in_cy_q[XY_W-1], in_cy_q} - {mean_y_q[XY_W-1], mean_y_q};
	assign dr     = {1'b0, in_r_q} - {1'b0, mean_r_q};
	assign dr_abs = dr[RAD_W] ? (RAD_W+1)'(0) - dr : dr;

	always_comb begin
		case (state_q)
			S_SQX:   mul_op = dx;
			S_SQY:   mul_op = dy;
			default: mul_op = {{(XY_W+1-TOL_W){1'b0}}, ctol_q};
		endcase
	end

	always_comb begin
		case (div_sel_q)
			DSEL_X:  dvd = sum_x_q;
			DSEL_Y:  dvd = sum_y_q;
			default: dvd = {{(SW-RW){1'b0}}, sum_r_q};
		endcase
		dvd_neg  = (div_sel_q != DSEL_R) && dvd[SW-1];
		dvd_mag  = dvd_neg ? SW'(0) - dvd : dvd;
		shifted  = {div_rem_q, div_quo_q[SW-1]};
		trial    = shifted - {1'b0, cnt_q};
		div_ge   = shifted >= {1'b0, cnt_q};
		rem_next = div_ge ? trial[CW-1:0] : shifted[CW-1:0];
		quo_next = {div_quo_q[SW-2:0], div_ge};
		quo_res  = div_neg_q ? SW'(0) - quo_next : quo_next;
	end

	assign cnt_w    = QW'(cnt_q);
	assign grp_h    = span_height(grp_bot_q, grp_top_q);
	assign grp_qual = (cnt_w >= QW'(mins_q)) && (grp_h >= minh_q);
	assign new_qual = (QW'(1) >= QW'(mins_q)) && (span_height(new_bot, new_top) >= minh_q);
	assign cnt_out  = (cnt_w > QW'(127)) ? CNT_W'(127) : cnt_w[CNT_W-1:0];
	assign pct_out  = (cnt_w >= QW'(10)) ? PCT_W'(100) : PCT_W'(cnt_w[3:0]) * PCT_W'(10);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		case (after_q)
			AFT_FEND:  after_state = S_FEND;
			AFT_START: after_state = S_START;
			default:   after_state = S_IDLE;
		endcase
	end

	assign apb_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[4:2])
			REG_THICKNESS:  prdata = APB_DW'(thick_q);
			REG_CENTER_TOL: prdata = APB_DW'(ctol_q);
			REG_RADIUS_TOL: prdata = APB_DW'(rtol_q);
			REG_MIN_SLICES: prdata = APB_DW'(mins_q);
			REG_MIN_HEIGHT: prdata = APB_DW'(minh_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= THICKNESS_RST;
			ctol_q  <= CENTER_TOL_RST;
			rtol_q  <= RADIUS_TOL_RST;
			mins_q  <= MIN_SLICES_RST;
			minh_q  <= MIN_HEIGHT_RST;
		end else if (apb_wr) begin
			case (paddr[4:2])
				REG_THICKNESS:  thick_q <= pwdata[THK_W-1:0];
				REG_CENTER_TOL: ctol_q  <= pwdata[TOL_W-1:0];
				REG_RADIUS_TOL: rtol_q  <= pwdata[TOL_W-1:0];
				REG_MIN_SLICES: mins_q  <= pwdata[MINS_W-1:0];
				REG_MIN_HEIGHT: minh_q  <= pwdata[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			after_q     <= AFT_DONE;
			dret_q      <= DRET_CMP;
			in_cx_q     <= '0;
			in_cy_q     <= '0;
			in_r_q      <= '0;
			in_ok_q     <= 1'b0;
			in_fend_q   <= 1'b0;
			in_z_q      <= '0;
			grp_open_q  <= 1'b0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_r_q     <= '0;
			grp_bot_q   <= '0;
			grp_top_q   <= '0;
			cnt_q       <= '0;
			next_id_q   <= '0;
			means_vld_q <= 1'b0;
			mean_x_q    <= '0;
			mean_y_q    <= '0;
			mean_r_q    <= '0;
			div_sel_q   <= DSEL_X;
			div_ld_q    <= 1'b0;
			div_neg_q   <= 1'b0;
			div_bit_q   <= '0;
			div_quo_q   <= '0;
			div_rem_q   <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tlast_q   <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						in_cx_q   <= s_tdata[15:0];
						in_cy_q   <= s_tdata[31:16];
						in_r_q    <= s_tdata[43:32];
						in_z_q    <= s_tdata[59:44];
						in_ok_q   <= s_tuser;
						in_fend_q <= s_tlast;
						state_q   <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!in_ok_q) begin
						after_q <= AFT_FEND;
						state_q <= S_CLOSE;
					end else if (!grp_open_q) begin
						state_q <= S_START;
					end else if (means_vld_q) begin
						state_q <= S_SQX;
					end else begin
						dret_q    <= DRET_CMP;
						div_sel_q <= DSEL_X;
						div_ld_q  <= 1'b1;
						state_q   <= S_DIV;
					end
				end
				S_START: begin
					grp_open_q  <= 1'b1;
					sum_x_q     <= SW'(in_cx_q);
					sum_y_q     <= SW'(in_cy_q);
					sum_r_q     <= RW'(in_r_q);
					grp_bot_q   <= new_bot;
					grp_top_q   <= new_top;
					cnt_q       <= CW'(1);
					mean_x_q    <= in_cx_q;
					mean_y_q    <= in_cy_q;
					mean_r_q    <= in_r_q;
					means_vld_q <= 1'b1;
					state_q     <= S_FEND;
				end
				S_DIV: begin
					if (div_ld_q) begin
						div_ld_q  <= 1'b0;
						div_neg_q <= dvd_neg;
						div_quo_q <= dvd_mag;
						div_rem_q <= '0;
						div_bit_q <= BW'(SW - 1);
					end else begin
						div_quo_q <= quo_next;
						div_rem_q <= rem_next;
						div_bit_q <= div_bit_q - BW'(1);
						if (div_bit_q == '0) begin
							case (div_sel_q)
								DSEL_X:  mean_x_q <= quo_res[XY_W-1:0];
								DSEL_Y:  mean_y_q <= quo_res[XY_W-1:0];
								default: mean_r_q <= quo_res[RAD_W-1:0];
							endcase
							if (div_sel_q == DSEL_R) begin
								means_vld_q <= 1'b1;
								state_q     <= (dret_q == DRET_EMIT) ? S_EMIT : S_SQX;
							end else begin
								div_sel_q <= div_sel_q + 2'd1;
								div_ld_q  <= 1'b1;
							end
						end
					end
				end
				S_SQX: begin
					prod_q  <= mul_op * mul_op;
					state_q <= S_SQY;
				end
				S_SQY: begin
					acc_q   <= {1'b0, prod_q};
					prod_q  <= mul_op * mul_op;
					state_q <= S_SQC;
				end
				S_SQC: begin
					acc_q   <= acc_q + {1'b0, prod_q};
					prod_q  <= mul_op * mul_op;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ((acc_q < {1'b0, prod_q}) && (dr_abs < {1'b0, rtol_q})) begin
						grp_top_q <= new_top;
						if (cnt_q < CW'(MAX_SLICES)) begin
							sum_x_q     <= sum_x_q + SW'(in_cx_q);
							sum_y_q     <= sum_y_q + SW'(in_cy_q);
							sum_r_q     <= sum_r_q + RW'(in_r_q);
							cnt_q       <= cnt_q + CW'(1);
							means_vld_q <= 1'b0;
						end
						state_q <= S_FEND;
					end else begin
						after_q <= AFT_START;
						state_q <= S_CLOSE;
					end
				end
				S_CLOSE: begin
					if (!grp_open_q) begin
						state_q <= after_state;
					end else begin
						grp_open_q <= 1'b0;
						if (!grp_qual) begin
							state_q <= after_state;
						end else if (means_vld_q) begin
							state_q <= S_EMIT;
						end else begin
							dret_q    <= DRET_EMIT;
							div_sel_q <= DSEL_X;
							div_ld_q  <= 1'b1;
							state_q   <= S_DIV;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tlast_q  <= !((after_q == AFT_START) && in_fend_q && new_qual);
						m_tdata_q  <= {6'd0, next_id_q, pct_out, cnt_out, grp_h, grp_top_q,
							grp_bot_q, mean_r_q, mean_y_q, mean_x_q};
						next_id_q  <= next_id_q + ID_W'(1);
						state_q    <= after_state;
					end
				end
				S_FEND: begin
					if (in_fend_q) begin
						after_q <= AFT_DONE;
						state_q <= S_CLOSE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		grp_open_q |-> (cnt_q != '0) && (cnt_q <= CW'(MAX_SLICES)))
		else $error("open group count out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q != '0))
		else $error("division by a zero slice count");

	a_means_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQX) |-> means_vld_q)
		else $error("distance test started on stale means");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> m_tvalid_q)
		else $error("emitted word did not reach the output register");

endmodule
